// ===== rtl/assert_macros.svh =====
// assertion macros used by the encoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

// ===== rtl/rcfe_pkg.sv =====
// package with constants and helper functions of the rotator command frame encoder
`timescale 1ns / 1ps
package rcfe_pkg;

   localparam int VALUE_W    = 19;
   localparam int MAG_W      = 17;
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 6;
   localparam int DIG_W      = 3;
   localparam int NUM_VALUES = 4;
   localparam int VAL_IDX_W  = 2;
   localparam int BCD_W      = 4;
   localparam int REQ_DATA_W = 80;

   localparam logic signed [VALUE_W-1:0] VALUE_LIMIT = 19'sd99999;
   localparam logic signed [VALUE_W-1:0] VALUE_FLOOR = -19'sd99999;

   localparam logic [POS_W-1:0] POS_SEQ_TENS  = 6'd4;
   localparam logic [POS_W-1:0] POS_SEQ_ONES  = 6'd5;
   localparam logic [POS_W-1:0] POS_MODE_HI   = 6'd6;
   localparam logic [POS_W-1:0] POS_MODE_LO   = 6'd7;
   localparam logic [POS_W-1:0] POS_T         = 6'd8;
   localparam logic [POS_W-1:0] POS_ZEROS_END = 6'd13;
   localparam logic [POS_W-1:0] POS_SIGN0     = 6'd14;
   localparam logic [POS_W-1:0] POS_SIGN1     = 6'd20;
   localparam logic [POS_W-1:0] POS_SIGN2     = 6'd26;
   localparam logic [POS_W-1:0] POS_SIGN3     = 6'd32;
   localparam logic [POS_W-1:0] POS_VAL_END   = 6'd37;
   localparam logic [POS_W-1:0] POS_CHK_HI    = 6'd38;
   localparam logic [POS_W-1:0] POS_CHK_LO    = 6'd39;
   localparam logic [POS_W-1:0] POS_CR        = 6'd40;
   localparam logic [POS_W-1:0] POS_LF        = 6'd41;

   localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_1     = 8'h31;
   localparam logic [BYTE_W-1:0] CHAR_5     = 8'h35;
   localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

   localparam logic [BCD_W-1:0] BCD_MAX = 4'd9;

   typedef logic [MAG_W-1:0] mag_type;

   // place value of the digit, most significant first
   function automatic mag_type pow10(input logic [DIG_W-1:0] dig);
      mag_type p;
      case (dig)
         3'd0: p = 17'd10000;
         3'd1: p = 17'd1000;
         3'd2: p = 17'd100;
         3'd3: p = 17'd10;
         3'd4: p = 17'd1;
         default: p = 17'd1;
      endcase
      return p;
   endfunction

   // uppercase hex character of a nibble
   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
      logic [BYTE_W-1:0] c;
      if (n < 4'd10) begin
         c = CHAR_0 + {4'd0, n};
      end else begin
         c = CHAR_A + {4'd0, n - 4'd10};
      end
      return c;
   endfunction

endpackage

// ===== rtl/rotator_command_frame_encoder_core.sv =====
// rotator command frame encoder top level: one command in, one 42-byte ascii frame out
// a command is registered in the pending register, then in the frame state registers
// throughput: one frame byte per cycle while rsp_tready does not stall the byte output port
// one command is held while the previous frame is still being sent
// reset: synchronous, active high; clears the sequence number to 0 and drops all
// pending and in-flight work
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rotator_command_frame_encoder_core
   import rcfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // az_target_centi, el_target_centi, az_rate_milli, el_rate_milli, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tx_byte
   output logic [BYTE_W-1:0]     rsp_tdata,
   output logic                  rsp_tlast
);

   // pending command
   logic                                pend_valid_ff, pend_valid_in;
   logic signed [VALUE_W-1:0]           pend_ff [NUM_VALUES];
   logic signed [VALUE_W-1:0]           pend_in [NUM_VALUES];

   // frame in progress
   logic                    active_ff, active_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [NUM_VALUES-1:0]   neg_ff, neg_in;
   mag_type                 mag_ff [NUM_VALUES];
   mag_type                 mag_in [NUM_VALUES];
   mag_type                 rem_ff, rem_in;
   logic [DIG_W-1:0]        dig_ff, dig_in;
   logic [BYTE_W-1:0]       sum_ff, sum_in;
   logic [BCD_W-1:0]        tens_ff, tens_in;
   logic [BCD_W-1:0]        ones_ff, ones_in;

   // output register
   logic                    out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]       out_byte_ff, out_byte_in;
   logic                    out_last_ff, out_last_in;

   logic                    req_fire;
   logic                    step;
   logic                    last_step;
   logic                    start;
   logic                    is_sign;
   logic                    in_payload;
   logic [VAL_IDX_W-1:0]    vi;
   mag_type                 place;
   mag_type                 sub;
   logic [BCD_W-1:0]        digit;
   logic [BYTE_W-1:0]       chk;
   logic [BYTE_W-1:0]       byte_val;
   mag_type                 sat_mag [NUM_VALUES];
   logic [NUM_VALUES-1:0]   sat_neg;

   assign req_fire   = req_tvalid && req_tready;
   assign step       = active_ff && (!out_valid_ff || rsp_tready);
   assign last_step  = step && (pos_ff == POS_LF);
   assign start      = pend_valid_ff && (!active_ff || last_step);
   assign req_tready = !pend_valid_ff || start;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

   // saturation and sign split, one lane per value
   always_comb begin
      for (int i = 0; i < NUM_VALUES; i++) begin
         if (pend_ff[i] > VALUE_LIMIT) begin
            sat_neg[i] = 1'b0;
            sat_mag[i] = VALUE_LIMIT[MAG_W-1:0];
         end else if (pend_ff[i] < VALUE_FLOOR) begin
            sat_neg[i] = 1'b1;
            sat_mag[i] = VALUE_LIMIT[MAG_W-1:0];
         end else if (pend_ff[i] < 0) begin
            sat_neg[i] = 1'b1;
            sat_mag[i] = mag_type'(-pend_ff[i]);
         end else begin
            sat_neg[i] = 1'b0;
            sat_mag[i] = pend_ff[i][MAG_W-1:0];
         end
      end
   end

   // one decimal digit of the current value, most significant first
   always_comb begin
      place = pow10(dig_ff);
      digit = '0;
      sub   = '0;
      for (int k = 1; k <= 9; k++) begin
         if (rem_ff >= mag_type'(k * int'(place))) begin
            digit = BCD_W'(k);
            sub   = mag_type'(k * int'(place));
         end
      end
   end

   always_comb begin
      vi = '0;
      case (pos_ff)
         POS_SIGN0: vi = 2'd0;
         POS_SIGN1: vi = 2'd1;
         POS_SIGN2: vi = 2'd2;
         POS_SIGN3: vi = 2'd3;
         default:   vi = 2'd0;
      endcase
   end

   assign is_sign    = (pos_ff == POS_SIGN0) || (pos_ff == POS_SIGN1) ||
                       (pos_ff == POS_SIGN2) || (pos_ff == POS_SIGN3);
   assign in_payload = (pos_ff >= POS_SEQ_TENS) && (pos_ff <= POS_VAL_END);
   assign chk        = 8'd0 - sum_ff;

   // frame byte at the current position
   always_comb begin
      if (pos_ff < POS_SEQ_TENS) begin
         byte_val = CHAR_5;
      end else if (pos_ff == POS_SEQ_TENS) begin
         byte_val = CHAR_0 + {4'd0, tens_ff};
      end else if (pos_ff == POS_SEQ_ONES) begin
         byte_val = CHAR_0 + {4'd0, ones_ff};
      end else if (pos_ff == POS_MODE_HI) begin
         byte_val = CHAR_0;
      end else if (pos_ff == POS_MODE_LO) begin
         byte_val = CHAR_1;
      end else if (pos_ff == POS_T) begin
         byte_val = CHAR_T;
      end else if (pos_ff <= POS_ZEROS_END) begin
         byte_val = CHAR_0;
      end else if (is_sign) begin
         byte_val = neg_ff[vi] ? CHAR_MINUS : CHAR_PLUS;
      end else if (pos_ff <= POS_VAL_END) begin
         byte_val = CHAR_0 + {4'd0, digit};
      end else if (pos_ff == POS_CHK_HI) begin
         byte_val = hex_char(chk[7:4]);
      end else if (pos_ff == POS_CHK_LO) begin
         byte_val = hex_char(chk[3:0]);
      end else if (pos_ff == POS_CR) begin
         byte_val = CHAR_CR;
      end else begin
         byte_val = CHAR_LF;
      end
   end

   // next state
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      active_in     = active_ff;
      pos_in        = pos_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      rem_in        = rem_ff;
      dig_in        = dig_ff;
      sum_in        = sum_ff;
      tens_in       = tens_ff;
      ones_in       = ones_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (step) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_val;
         out_last_in  = (pos_ff == POS_LF);
         pos_in       = pos_ff + 6'd1;
         if (in_payload) begin
            sum_in = sum_ff + byte_val;
         end
         if (is_sign) begin
            rem_in = mag_ff[vi];
            dig_in = '0;
         end else if ((pos_ff > POS_SIGN0) && (pos_ff <= POS_VAL_END)) begin
            rem_in = rem_ff - sub;
            dig_in = dig_ff + 3'd1;
         end
         if (pos_ff == POS_LF) begin
            active_in = 1'b0;
            if (ones_ff == BCD_MAX) begin
               ones_in = '0;
               tens_in = (tens_ff == BCD_MAX) ? '0 : tens_ff + 4'd1;
            end else begin
               ones_in = ones_ff + 4'd1;
            end
         end
      end

      if (start) begin
         active_in     = 1'b1;
         pos_in        = '0;
         sum_in        = '0;
         neg_in        = sat_neg;
         mag_in        = sat_mag;
         pend_valid_in = 1'b0;
      end

      if (req_fire) begin
         pend_valid_in = 1'b1;
         for (int i = 0; i < NUM_VALUES; i++) begin
            pend_in[i] = req_tdata[i*VALUE_W +: VALUE_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         active_ff     <= 1'b0;
         pos_ff        <= '0;
         dig_ff        <= '0;
         tens_ff       <= '0;
         ones_ff       <= '0;
         out_valid_ff  <= 1'b0;
         out_last_ff   <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         active_ff     <= active_in;
         pos_ff        <= pos_in;
         dig_ff        <= dig_in;
         tens_ff       <= tens_in;
         ones_ff       <= ones_in;
         out_valid_ff  <= out_valid_in;
         out_last_ff   <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      sum_ff      <= sum_in;
      out_byte_ff <= out_byte_in;
   end

   `ASSERT_IMPLY(a_last_is_lf, clock, reset, rsp_tvalid && rsp_tlast,
      rsp_tdata == CHAR_LF, "frame end without line feed")
   `ASSERT_IMPLY(a_pos_in_frame, clock, reset, active_ff,
      pos_ff <= POS_LF, "frame position beyond last byte")
   `ASSERT_ALWAYS(a_seq_bcd, clock, reset,
      (tens_ff <= BCD_MAX) && (ones_ff <= BCD_MAX), "sequence digit out of range")
   `ASSERT_IMPLY(a_frame_restart, clock, reset, active_ff && (pos_ff == POS_LF) && step,
      ##1 (pos_ff == '0) || !active_ff, "frame did not restart after last byte")

endmodule

// ===== verif/tb_rotator_command_frame_encoder_core.sv =====
// testbench of the rotator command frame encoder: directed and random commands, predicted ascii frames
`timescale 1ns / 1ps
module tb_rotator_command_frame_encoder_core
   import rcfe_pkg::*;
();

   localparam int FRAME_LEN     = 42;
   localparam int RANDOM_CMDS   = 150;
   localparam int IDLE_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 50;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AFTER    = 1500;
   localparam logic [6:0] SEQ_WRAP = 7'd100;

   typedef struct packed {
      logic signed [VALUE_W-1:0] el_rate;
      logic signed [VALUE_W-1:0] az_rate;
      logic signed [VALUE_W-1:0] el_target;
      logic signed [VALUE_W-1:0] az_target;
   } command_type;

   typedef struct {
      logic [BYTE_W-1:0] tx;
      logic              last;
   } frame_byte_type;

   typedef logic [BYTE_W-1:0] frame_type [FRAME_LEN];

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // az_target_centi, el_target_centi, az_rate_milli, el_rate_milli, zero fill
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tx_byte
   logic [BYTE_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;

   command_type    command_backlog[$];
   frame_byte_type pending_frame_bytes[$];
   command_type    current_cmd = '0;
   logic [6:0]     seq_model = '0;
   int             commands_total = 0;
   int             commands_accepted = 0;
   int             errors = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;
   int             bytes_taken = 0;
   int             pattern = 0;
   int             pattern_left = 0;
   int             idle_cycles = 0;

   rotator_command_frame_encoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // builds the frame for one command with the given sequence number
   function automatic void encode_frame(input logic [6:0] seq_in, input command_type c,
                                        output frame_type f);
      logic [6:0]                seq;
      logic signed [VALUE_W-1:0] vals [NUM_VALUES];
      logic signed [VALUE_W-1:0] v;
      int unsigned               mag;
      logic [BYTE_W-1:0]         sum;
      logic [BYTE_W-1:0]         chk;
      logic [3:0]                nib;
      int                        p;
      seq = (seq_in >= SEQ_WRAP) ? 7'd0 : seq_in;
      vals[0] = c.az_target;
      vals[1] = c.el_target;
      vals[2] = c.az_rate;
      vals[3] = c.el_rate;
      for (int k = 0; k < 4; k++) begin
         f[k] = CHAR_5;
      end
      f[POS_SEQ_TENS] = CHAR_0 + BYTE_W'(seq / 10);
      f[POS_SEQ_ONES] = CHAR_0 + BYTE_W'(seq % 10);
      f[POS_MODE_HI]  = CHAR_0;
      f[POS_MODE_LO]  = CHAR_1;
      f[POS_T]        = CHAR_T;
      for (int k = POS_T + 1; k <= POS_ZEROS_END; k++) begin
         f[k] = CHAR_0;
      end
      p = POS_SIGN0;
      for (int i = 0; i < NUM_VALUES; i++) begin
         v = vals[i];
         if (v > VALUE_LIMIT) v = VALUE_LIMIT;
         if (v < VALUE_FLOOR) v = VALUE_FLOOR;
         if (v < 0) begin
            f[p] = CHAR_MINUS;
            mag = -int'(v);
         end else begin
            f[p] = CHAR_PLUS;
            mag = int'(v);
         end
         for (int d = 5; d >= 1; d--) begin
            f[p + d] = CHAR_0 + BYTE_W'(mag % 10);
            mag = mag / 10;
         end
         p = p + 6;
      end
      sum = '0;
      for (int k = POS_SEQ_TENS; k <= POS_VAL_END; k++) begin
         sum = sum + f[k];
      end
      chk = 8'd0 - sum;
      for (int h = 0; h < 2; h++) begin
         nib = (h == 0) ? chk[7:4] : chk[3:0];
         f[POS_CHK_HI + h] = (nib < 4'd10) ? CHAR_0 + BYTE_W'(nib)
                                           : CHAR_A + BYTE_W'(nib - 4'd10);
      end
      f[POS_CR] = CHAR_CR;
      f[POS_LF] = CHAR_LF;
   endfunction

   task automatic queue_frame(input command_type c);
      frame_type f;
      frame_byte_type b;
      encode_frame(seq_model, c, f);
      seq_model = (seq_model >= SEQ_WRAP) ? 7'd1 : seq_model + 7'd1;
      for (int k = 0; k < FRAME_LEN; k++) begin
         b.tx   = f[k];
         b.last = (k == FRAME_LEN - 1);
         pending_frame_bytes.push_back(b);
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] random_value();
      int v;
      case ($urandom_range(0, 5))
         0, 1: v = int'($urandom_range(0, 19'h7FFFF));
         2: v = $urandom_range(0, 99999);
         3: v = $urandom_range(0, 99);
         4: v = $urandom_range(99990, 100010);
         default: v = 0;
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return VALUE_W'(v);
   endfunction

   function automatic command_type make_command(input int az, input int el, input int azr,
                                                input int elr);
      command_type c;
      c.az_target = VALUE_W'(az);
      c.el_target = VALUE_W'(el);
      c.az_rate   = VALUE_W'(azr);
      c.el_rate   = VALUE_W'(elr);
      return c;
   endfunction

   initial begin
      command_type c;
      frame_type   f;
      command_backlog.push_back(make_command(0, 0, 0, 0));
      command_backlog.push_back(make_command(99999, -99999, 1, -1));
      command_backlog.push_back(make_command(100000, -100000, 262143, -262144));
      command_backlog.push_back(make_command(262143, 262143, 262143, 262143));
      command_backlog.push_back(make_command(-262144, -262144, -262144, -262144));
      command_backlog.push_back(make_command(-1, 1, -100000, 100000));
      command_backlog.push_back(make_command(12345, -54321, 9, -90));
      command_backlog.push_back(make_command(1000, -10, 99, 100));
      // checksum of zero, searched for the sequence number this frame will carry
      c = make_command(0, 250, -4321, 777);
      for (int az = 0; az < 1000; az++) begin
         c.az_target = VALUE_W'(az);
         encode_frame(7'(command_backlog.size()), c, f);
         if (f[POS_CHK_HI] == CHAR_0 && f[POS_CHK_LO] == CHAR_0) break;
      end
      command_backlog.push_back(c);
      command_backlog.push_back(make_command(19'h2AAAA, 19'h55555, 19'h2AAAA, 19'h55555));
      command_backlog.push_back(make_command(19'h55555, 19'h2AAAA, 19'h55555, 19'h2AAAA));
      command_backlog.push_back(make_command(-99998, 99998, 5, 50000));
      command_backlog.push_back(make_command(-100001, 100001, -99999, 99999));
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         c.az_target = random_value();
         c.el_target = random_value();
         c.az_rate   = random_value();
         c.el_rate   = random_value();
         command_backlog.push_back(c);
      end
      commands_total = command_backlog.size();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (commands_accepted < commands_total || pending_frame_bytes.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // command sender: bursts of transactions separated by random gaps
   always @(posedge clock) begin : drive_commands
      logic offering;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         offering = req_tvalid;
         if (req_tvalid && req_tready) begin
            queue_frame(current_cmd);
            commands_accepted++;
            offering = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
            end
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (command_backlog.size() > 0) begin
               current_cmd = command_backlog.pop_front();
               offering = 1'b1;
            end
         end
         req_tvalid <= offering;
         req_tdata  <= REQ_DATA_W'(current_cmd);
      end
   end

   // byte receiver: changing stall patterns and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) bytes_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern      = $urandom_range(0, 3);
               pattern_left = $urandom_range(4, 90);
            end else begin
               pattern_left--;
            end
            case (pattern)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // byte checker
   always @(posedge clock) begin : check_bytes
      frame_byte_type exp_byte;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_frame_bytes.size() == 0) begin
            $error("unexpected rsp transaction: tx_byte %h tlast %b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            exp_byte = pending_frame_bytes.pop_front();
            if (rsp_tdata !== exp_byte.tx) begin
               $error("tx_byte: expected %h, actual %h", exp_byte.tx, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== exp_byte.last) begin
               $error("frame_end: expected %b, actual %b", exp_byte.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== rotator_command_frame_encoder_core.f =====
+incdir+rtl
rtl/rcfe_pkg.sv
rtl/rotator_command_frame_encoder_core.sv
verif/tb_rotator_command_frame_encoder_core.sv
